FILE: hdl/fca_pkg.sv
// shared types and constants for the chain allocator
// no dependencies; imported by every module of the block
package fca_pkg;

  // table geometry, fixed by the 10-bit block fields
  localparam int NUM_BLOCKS = 1024;
  localparam int BLK_W      = 10;
  localparam int CNT_W      = 11;

  // stream widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  // command codes
  localparam logic [IN_USER_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [IN_USER_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [IN_USER_W-1:0] CMD_READ  = 2'd2;

  // one table entry
  typedef struct packed {
    logic             used;
    logic             eoc;
    logic [BLK_W-1:0] link;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_LINK_END,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_READ_WAIT,
    ST_RESP
  } state_t;

  // result selection
  typedef enum logic [2:0] {
    RES_EMPTY,
    RES_NOSPACE,
    RES_ALLOC,
    RES_ZERO,
    RES_READ
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     clear;
    logic     scan_start;
    logic     scan;
    logic     link_end;
    logic     rd_cur;
    logic     walk_clr;
    logic     set_res;
    res_sel_t res_sel;
    logic     push;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                 clear_done;
    logic [IN_USER_W-1:0] op;
    logic                 count_zero;
    logic                 no_space;
    logic                 scan_done;
    logic                 walk_stop;
    logic                 out_free;
  } dp_stat_t;

endpackage

FILE: hdl/fat_chain_allocator.sv
// top level of the chain allocator: controller plus datapath
// depends on fca_pkg, fca_ctrl and fca_datapath
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: block_count, chain_head; tuser: command
// m_axis    out  m_axis_tvalid/tready        tdata: status, block, end_of_chain
//
// request to result: an alloc of n blocks waits on the table scan through the single
// memory read port, in index order up to the n-th lowest free block; a free reads each
// visited chain entry and clears it if used; read_next does one table read; zero or failed
// allocs and unknown commands answer from decode; the controller returns to idle before the next request
// reset: a clearing pass writes all 1024 entries, one per cycle, with
// s_axis_tready low until the pass ends
// stalls: a result waits in the output register; the next request is taken
// meanwhile and its result waits until the output register frees
module fat_chain_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [10:0] block_count, [20:11] chain_head, [23:21] zero
  input  logic [fca_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] command
  input  logic [fca_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] status, [10:1] block, [11] end_of_chain, [15:12] zero
  output logic [fca_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import fca_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  fca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table and registers
  fca_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: hdl/fca_ctrl.sv
// controller state machine of the chain allocator
// depends on fca_pkg for state, command and status types
module fca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fca_pkg::dp_stat_t stat,
  output fca_pkg::dp_cmd_t  cmd
);
  import fca_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.res_sel = RES_ZERO;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.op)
          CMD_ALLOC: begin
            if (stat.count_zero) begin
              cmd.set_res = 1'b1;
              cmd.res_sel = RES_EMPTY;
              state_next  = ST_RESP;
            end else if (stat.no_space) begin
              cmd.set_res = 1'b1;
              cmd.res_sel = RES_NOSPACE;
              state_next  = ST_RESP;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          CMD_FREE: begin
            state_next = ST_WALK_RD;
          end
          CMD_READ: begin
            cmd.rd_cur = 1'b1;
            state_next = ST_READ_WAIT;
          end
          default: begin
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_ZERO;
            state_next  = ST_RESP;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = ST_LINK_END;
      end
      ST_LINK_END: begin
        cmd.link_end = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_sel  = RES_ALLOC;
        state_next   = ST_RESP;
      end
      ST_WALK_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        cmd.walk_clr = 1'b1;
        if (stat.walk_stop) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_ZERO;
          state_next  = ST_RESP;
        end else begin
          state_next = ST_WALK_RD;
        end
      end
      ST_READ_WAIT: begin
        cmd.set_res = 1'b1;
        cmd.res_sel = RES_READ;
        state_next  = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/fca_datapath.sv
// datapath of the chain allocator: link table memory, scan and walk
// registers, free counter and output register; depends on fca_pkg
module fca_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [fca_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [fca_pkg::IN_USER_W-1:0]    in_user,
  input  fca_pkg::dp_cmd_t                 cmd,
  output fca_pkg::dp_stat_t                stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fca_pkg::OUT_DATA_W-1:0]   out_data
);
  import fca_pkg::*;

  entry_t mem [NUM_BLOCKS];
  entry_t rdata;
  entry_t wdata;
  logic             we;
  logic [BLK_W-1:0] waddr;
  logic [BLK_W-1:0] raddr;
  logic             rd_en;

  logic [IN_USER_W-1:0] op;
  logic [CNT_W-1:0]     count_r;
  logic [BLK_W-1:0]     cur;
  logic [CNT_W-1:0]     steps;
  logic [CNT_W-1:0]     free_cnt;
  logic [BLK_W-1:0]     clr_addr;
  logic [CNT_W-1:0]     scan_addr;
  logic                 chk_valid;
  logic [BLK_W-1:0]     chk_addr;
  logic [CNT_W-1:0]     taken;
  logic [BLK_W-1:0]     first;
  logic [BLK_W-1:0]     prev;
  logic                 found;

  logic             res_status;
  logic [BLK_W-1:0] res_block;
  logic             res_eoc;

  assign found = chk_valid && !rdata.used;

  // status to the controller
  always_comb begin
    stat.clear_done = (clr_addr == BLK_W'(NUM_BLOCKS - 1));
    stat.op         = op;
    stat.count_zero = (count_r == '0);
    stat.no_space   = (free_cnt < count_r);
    stat.scan_done  = found && ((taken + CNT_W'(1)) == count_r);
    stat.walk_stop  = !rdata.used || rdata.eoc || (steps == CNT_W'(NUM_BLOCKS - 1));
    stat.out_free   = !out_valid || out_ready;
  end

  // write port select, one writer per cycle
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = '0;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (cmd.scan && found && (taken != '0)) begin
      we         = 1'b1;
      waddr      = prev;
      wdata.used = 1'b1;
      wdata.link = chk_addr;
    end else if (cmd.link_end) begin
      we         = 1'b1;
      waddr      = prev;
      wdata.used = 1'b1;
      wdata.eoc  = 1'b1;
    end else if (cmd.walk_clr && rdata.used) begin
      we    = 1'b1;
      waddr = cur;
    end
  end

  assign raddr = cmd.scan ? scan_addr[BLK_W-1:0] : cur;
  assign rd_en = cmd.scan | cmd.rd_cur;

  // link table memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      free_cnt  <= CNT_W'(NUM_BLOCKS);
      clr_addr  <= '0;
      chk_valid <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + BLK_W'(1);
      if (cmd.scan_start) begin
        chk_valid <= 1'b0;
      end else if (cmd.scan) begin
        chk_valid <= 1'b1;
      end
      if (cmd.link_end) begin
        free_cnt <= free_cnt - count_r;
      end else if (cmd.walk_clr && rdata.used) begin
        free_cnt <= free_cnt + CNT_W'(1);
      end
    end
  end

  // request capture, scan and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_user;
      count_r <= in_data[CNT_W-1:0];
      cur     <= in_data[CNT_W+BLK_W-1:CNT_W];
      steps   <= '0;
    end
    if (cmd.scan_start) begin
      scan_addr <= '0;
      taken     <= '0;
    end
    if (cmd.scan) begin
      scan_addr <= scan_addr + CNT_W'(1);
      chk_addr  <= scan_addr[BLK_W-1:0];
      if (found) begin
        if (taken == '0) first <= chk_addr;
        prev  <= chk_addr;
        taken <= taken + CNT_W'(1);
      end
    end
    if (cmd.walk_clr) begin
      cur   <= rdata.link;
      steps <= steps + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      case (cmd.res_sel)
        RES_EMPTY: begin
          res_status <= 1'b0;
          res_block  <= '0;
          res_eoc    <= 1'b1;
        end
        RES_NOSPACE: begin
          res_status <= 1'b1;
          res_block  <= '0;
          res_eoc    <= 1'b1;
        end
        RES_ALLOC: begin
          res_status <= 1'b0;
          res_block  <= first;
          res_eoc    <= 1'b0;
        end
        RES_READ: begin
          res_status <= 1'b0;
          res_block  <= rdata.link;
          res_eoc    <= rdata.eoc;
        end
        default: begin
          res_status <= 1'b0;
          res_block  <= '0;
          res_eoc    <= 1'b0;
        end
      endcase
    end
  end

  // output stage, holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data <= {(OUT_DATA_W - BLK_W - 2)'(0), res_eoc, res_block, res_status};
    end
  end

endmodule

FILE: hdl/fca_checker.sv
// port-level checks for the chain allocator, bound to the top level
// depends on fca_pkg and fat_chain_allocator
module fca_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fca_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import fca_pkg::*;

  // clearing pass blocks requests right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request taken during clearing pass");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

  // a new result only appears after the request side was busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);

FILE: sim/tb_fat_chain_allocator.sv
// self-checking testbench for fat_chain_allocator: directed table, then random chain traffic
// depends on fca_pkg and the fat_chain_allocator rtl; a built-in link-table predictor checks results
module tb_fat_chain_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import fca_pkg::CMD_ALLOC;
  import fca_pkg::CMD_FREE;
  import fca_pkg::CMD_READ;

  localparam int NB = fca_pkg::NUM_BLOCKS;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_NOSPACE = 1'b1;
  localparam int N_RANDOM    = 555;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] count;
    logic [9:0]  start;
  } fat_request_t;

  typedef struct packed {
    logic       status;
    logic [9:0] block;
    logic       eoc;
  } chain_result_t;

  typedef struct {
    fat_request_t  rq;
    bit            fixed;
    chain_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_valid;
  logic [fca_pkg::IN_DATA_W-1:0] s_data;
  logic [fca_pkg::IN_USER_W-1:0] s_user;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic m_ready;
  logic [fca_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // predictor copy of the table
  logic [9:0] fat_link [NB];
  bit         fat_used [NB];
  bit         fat_end  [NB];

  chain_result_t pending_results[$];
  logic [9:0]    chain_heads[$];
  dir_row_t      dir_rows[$];

  // request currently on the input bus
  fat_request_t  cur_req;
  bit            cur_fixed;
  chain_result_t cur_want;

  int err_n = 0;
  int sent_n = 0;
  int cycle_n = 0;
  int n_alloc = 0, n_free = 0, n_read = 0, n_other = 0, n_nospace = 0, n_checked = 0;
  bit pressure_done = 1'b0;
  bit tb_done = 1'b0;

  fat_chain_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_n++;
    if (err_n <= 40) $display("mismatch @%0d: %s", cycle_n, msg);
  endtask

  function automatic int free_blocks();
    int n;
    n = 0;
    for (int i = 0; i < NB; i++) if (!fat_used[i]) n++;
    return n;
  endfunction

  // expected result of one request, updating the predictor table
  function automatic chain_result_t predict_chain_op(fat_request_t rq);
    chain_result_t r;
    int taken, prev, cur;
    logic [9:0] nxt;
    bit is_last;
    r = '0;
    case (rq.cmd)
      CMD_ALLOC: begin
        if (rq.count == 0) begin
          r.eoc = 1'b1;
        end else if (free_blocks() < int'(rq.count)) begin
          r.status = STAT_NOSPACE;
          r.eoc = 1'b1;
        end else begin
          taken = 0;
          prev = 0;
          // lowest free blocks, each becomes the new tail
          for (int i = 0; i < NB && taken < int'(rq.count); i++) begin
            if (!fat_used[i]) begin
              fat_used[i] = 1'b1;
              fat_end[i] = 1'b1;
              fat_link[i] = '0;
              if (taken == 0) begin
                r.block = 10'(i);
              end else begin
                fat_end[prev] = 1'b0;
                fat_link[prev] = 10'(i);
              end
              prev = i;
              taken++;
            end
          end
        end
      end
      CMD_FREE: begin
        cur = int'(rq.start);
        // walk until the tail, a free entry, or the step bound
        for (int steps = 0; steps < NB; steps++) begin
          if (!fat_used[cur]) break;
          nxt = fat_link[cur];
          is_last = fat_end[cur];
          fat_used[cur] = 1'b0;
          fat_end[cur] = 1'b0;
          fat_link[cur] = '0;
          if (is_last) break;
          cur = int'(nxt);
        end
      end
      CMD_READ: begin
        r.block = fat_link[rq.start];
        r.eoc = fat_end[rq.start];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random request, mostly well-formed chain traffic
  function automatic fat_request_t pick_random();
    fat_request_t rq;
    int r, k, sel, base;
    rq = '0;
    r = $urandom_range(0, 99);
    // keep the table from staying full
    if (r < 38 && chain_heads.size() > 0 && free_blocks() < 128) r = 50;
    if (r < 38) begin
      rq.cmd = CMD_ALLOC;
      k = $urandom_range(0, 99);
      if (k < 8) rq.count = 0;
      else if (k < 82) rq.count = 11'($urandom_range(1, 8));
      else if (k < 95) rq.count = 11'($urandom_range(9, 64));
      else rq.count = 11'($urandom_range(65, 2047));
      rq.start = 10'($urandom_range(0, NB - 1));
    end else if (r < 68) begin
      rq.cmd = CMD_FREE;
      rq.count = 11'($urandom_range(0, 2047));
      if (chain_heads.size() > 0 && $urandom_range(0, 4) != 0) begin
        sel = $urandom_range(0, chain_heads.size() - 1);
        rq.start = chain_heads[sel];
        chain_heads.delete(sel);
      end else begin
        rq.start = 10'($urandom_range(0, NB - 1));
      end
    end else if (r < 95) begin
      rq.cmd = CMD_READ;
      rq.count = 11'($urandom_range(0, 2047));
      k = $urandom_range(0, 2);
      if (k == 0 && chain_heads.size() > 0) begin
        rq.start = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
      end else if (k == 1) begin
        // next used entry at or after a random point, often mid-chain
        base = $urandom_range(0, NB - 1);
        rq.start = 10'(base);
        for (int j = 0; j < NB; j++) begin
          if (fat_used[(base + j) % NB]) begin
            rq.start = 10'((base + j) % NB);
            break;
          end
        end
      end else begin
        rq.start = 10'($urandom_range(0, NB - 1));
      end
    end else begin
      rq.cmd = CMD_UNUSED;
      rq.count = 11'($urandom_range(0, 2047));
      rq.start = 10'($urandom_range(0, NB - 1));
    end
    return rq;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input int count, input int start,
                         input bit fixed, input logic st, input int blk, input logic eoc);
    dir_row_t row;
    row.rq = '{cmd: cmd, count: 11'(count), start: 10'(start)};
    row.fixed = fixed;
    row.want = '{status: st, block: 10'(blk), eoc: eoc};
    dir_rows.push_back(row);
  endtask

  // offer one request after a random gap and hold it until taken
  task automatic send_request(input int idx);
    int n;
    fat_request_t rq;
    n = pick_gap();
    repeat (n) begin
      @(negedge clk);
      s_valid = 1'b0;
    end
    @(negedge clk);
    if (idx < dir_rows.size()) begin
      rq = dir_rows[idx].rq;
      cur_fixed = dir_rows[idx].fixed;
      cur_want = dir_rows[idx].want;
    end else begin
      rq = pick_random();
      cur_fixed = 1'b0;
    end
    cur_req = rq;
    s_data = {3'b000, rq.start, rq.count};
    s_user = rq.cmd;
    s_valid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sent_n++;
  endtask

  // result check and request prediction
  always @(posedge clk) begin
    chain_result_t got, want, pred;
    if (!rst) begin
      if (m_axis_tvalid && m_ready) begin
        got.status = m_axis_tdata[0];
        got.block = m_axis_tdata[10:1];
        got.eoc = m_axis_tdata[11];
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h with no request pending", m_axis_tdata));
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.block != want.block)
            report_mismatch($sformatf("block %0d, expected %0d", got.block, want.block));
          if (got.eoc != want.eoc)
            report_mismatch($sformatf("end_of_chain %0d, expected %0d", got.eoc, want.eoc));
        end
      end
      if (s_valid && s_axis_tready) begin
        pred = predict_chain_op(cur_req);
        pending_results.push_back(cur_fixed ? cur_want : pred);
        case (cur_req.cmd)
          CMD_ALLOC: begin
            n_alloc++;
            if (pred.status == STAT_NOSPACE) n_nospace++;
            else if (cur_req.count != 0) chain_heads.push_back(pred.block);
          end
          CMD_FREE: n_free++;
          CMD_READ: n_read++;
          default:  n_other++;
        endcase
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_n,
               pending_results.size());
      $display("[fat_chain_allocator] ERROR");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int run;
    m_ready = 1'b0;
    @(negedge clk);
    while (!tb_done) begin
      if (!pressure_done && sent_n >= 150) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_ready = 1'b0;
        end
        pressure_done = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        run = $urandom_range(1, 24);
        repeat (run) begin
          @(negedge clk);
          m_ready = 1'b1;
        end
      end else begin
        run = pick_gap();
        if (run == 0) run = 1;
        repeat (run) begin
          @(negedge clk);
          m_ready = 1'b0;
        end
      end
    end
  end

  // request side
  initial begin
    rst = 1'b1;
    s_valid = 1'b0;
    s_data = '0;
    s_user = '0;
    cur_req = '0;
    cur_fixed = 1'b0;
    cur_want = '0;
    for (int i = 0; i < NB; i++) begin
      fat_link[i] = '0;
      fat_used[i] = 1'b0;
      fat_end[i] = 1'b0;
    end

    // empty table, extremes, no space, full table
    add_row(CMD_READ,      0,    0, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_READ,      0, 1023, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_ALLOC,     0,    0, 1, STAT_OK,      0, 1'b1);
    add_row(CMD_ALLOC,     1,    0, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_READ,      0,    0, 1, STAT_OK,      0, 1'b1);
    add_row(CMD_ALLOC,     3,    0, 1, STAT_OK,      1, 1'b0);
    add_row(CMD_READ,      0,    1, 1, STAT_OK,      2, 1'b0);
    add_row(CMD_READ,      0,    3, 1, STAT_OK,      0, 1'b1);
    add_row(CMD_ALLOC,  2047,    0, 1, STAT_NOSPACE, 0, 1'b1);
    add_row(CMD_ALLOC,  1021,    0, 1, STAT_NOSPACE, 0, 1'b1);
    add_row(CMD_ALLOC,  1020,    0, 1, STAT_OK,      4, 1'b0);
    add_row(CMD_ALLOC,     1,    0, 1, STAT_NOSPACE, 0, 1'b1);
    add_row(CMD_READ,      0, 1023, 1, STAT_OK,      0, 1'b1);
    // free, free of a free entry, free from mid-chain
    add_row(CMD_FREE,      0,    0, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_FREE,      0,    0, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_ALLOC,     1,    0, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_FREE,      0,    2, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_READ,      0,    1, 0, STAT_OK,      0, 1'b0);
    add_row(CMD_FREE,      0,    1, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_READ,      0,    2, 0, STAT_OK,      0, 1'b0);
    add_row(CMD_UNUSED, 2047, 1023, 1, STAT_OK,      0, 1'b0);
    // long walks and a whole-table chain
    add_row(CMD_FREE,      0,    4, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_READ,      0,  500, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_ALLOC,  1024,    0, 1, STAT_NOSPACE, 0, 1'b1);
    add_row(CMD_FREE,      0,    0, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_ALLOC,  1024,    0, 1, STAT_OK,      0, 1'b0);
    add_row(CMD_FREE,      0,    0, 1, STAT_OK,      0, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < dir_rows.size() + N_RANDOM; i++) send_request(i);
    @(negedge clk);
    s_valid = 1'b0;

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    tb_done = 1'b1;

    $display("requests: %0d alloc (%0d without space), %0d free, %0d read, %0d unknown",
             n_alloc, n_nospace, n_free, n_read, n_other);
    $display("results checked: %0d, mismatches: %0d, cycles: %0d", n_checked, err_n, cycle_n);
    if (err_n == 0) begin
      $display("[fat_chain_allocator] OK");
    end else begin
      $display("[fat_chain_allocator] ERROR");
    end
    $finish;
  end

endmodule
